>>> rtl/core/cds_pkg.sv
package cds_pkg;

  // step direction
  typedef enum logic {
    OP_NEXT = 1'b0,
    OP_PREV = 1'b1
  } op_t;

  localparam logic [3:0]  MONTH_JAN   = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [4:0]  DAYS_LONG   = 5'd31;
  localparam logic [4:0]  DAYS_SHORT  = 5'd30;
  localparam logic [4:0]  DAYS_FEB    = 5'd28;
  localparam logic [4:0]  DAYS_FEB_LP = 5'd29;

  // floor(y * DIV25_RECIP / 2^DIV25_SHIFT) is y/25 or one below, for any 16-bit y
  localparam logic [15:0] DIV25_RECIP = 16'd41943;
  localparam int          DIV25_SHIFT = 20;
  localparam int          QUOT_W      = 12;
  localparam logic [5:0]  REM_25      = 6'd25;

  // stage 1 -> stage 2
  typedef struct packed {
    op_t               op;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [15:0]       year;
    logic [QUOT_W-1:0] quot;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    op_t         op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        leap;
    logic [4:0]  len;
    logic        bad;
  } s2_t;

  // days in month m; anything outside 1..12 counts as February
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAYS_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = DAYS_SHORT;
      default:                                    d = leap ? DAYS_FEB_LP : DAYS_FEB;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/cds_in_if.sv
interface cds_in_if;
  logic              valid;
  logic              ready;
  cds_pkg::op_t      operation;
  logic [4:0]        day;
  logic [3:0]        month;
  logic [15:0]       year;

  modport source (output valid, output operation, output day, output month, output year,
                  input ready);
  modport sink   (input valid, input operation, input day, input month, input year,
                  output ready);
endinterface

>>> rtl/core/cds_out_if.sv
interface cds_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  new_day;
  logic [3:0]  new_month;
  logic [15:0] new_year;
  logic [4:0]  month_length;
  logic        bad_date;

  modport source (output valid, output new_day, output new_month, output new_year,
                  output month_length, output bad_date, input ready);
  modport sink   (input valid, input new_day, input new_month, input new_year,
                  input month_length, input bad_date, output ready);
endinterface

>>> rtl/core/cds_div25.sv
// stage 1: approximate year / 25 by reciprocal multiply
module cds_div25 (
  input  logic         clk,
  input  logic         rst,
  cds_in_if.sink       request,
  output cds_pkg::s1_t stage,
  output logic         stage_valid,
  input  logic         stage_ready
);

  logic        load;
  logic [31:0] prod;

  assign request.ready = !stage_valid || stage_ready;
  assign load          = request.valid && request.ready;
  assign prod          = 32'(request.year) * 32'(cds_pkg::DIV25_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (request.ready) begin
      stage_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.op    <= request.operation;
      stage.day   <= request.day;
      stage.month <= request.month;
      stage.year  <= request.year;
      stage.quot  <= prod[cds_pkg::DIV25_SHIFT +: cds_pkg::QUOT_W];
    end
  end

endmodule

>>> rtl/core/cds_decode.sv
// stage 2: leap year, month length, validity
module cds_decode (
  input  logic         clk,
  input  logic         rst,
  input  cds_pkg::s1_t up,
  input  logic         up_valid,
  output logic         up_ready,
  output cds_pkg::s2_t stage,
  output logic         stage_valid,
  input  logic         stage_ready
);

  logic [15:0] times25;
  logic [15:0] diff;
  logic [5:0]  rem;
  logic        div25;
  logic        leap;
  logic [4:0]  len;
  logic        bad;

  // 25*q = 16q + 8q + q; remainder lands in 0..49
  assign times25 = {up.quot, 4'b0} + {1'b0, up.quot, 3'b0} + {4'b0, up.quot};
  assign diff    = up.year - times25;
  assign rem     = diff[5:0];
  assign div25   = (rem == 6'd0) || (rem == cds_pkg::REM_25);
  // div by 4, and not a century unless div by 400 (= div by 16 and 25)
  assign leap    = (up.year[1:0] == 2'b00) && (!div25 || (up.year[3:0] == 4'b0000));
  assign len     = cds_pkg::month_days(up.month, leap);
  assign bad     = (up.month == 4'd0) || (up.month > cds_pkg::MONTH_DEC) ||
                   (up.day == 5'd0) || (up.day > len);

  assign up_ready = !stage_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (up_ready) begin
      stage_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      stage.op    <= up.op;
      stage.day   <= up.day;
      stage.month <= up.month;
      stage.year  <= up.year;
      stage.leap  <= leap;
      stage.len   <= len;
      stage.bad   <= bad;
    end
  end

endmodule

>>> rtl/core/cds_step.sv
// stage 3: form the neighbouring date, result register
module cds_step (
  input  logic         clk,
  input  logic         rst,
  input  cds_pkg::s2_t up,
  input  logic         up_valid,
  output logic         up_ready,
  cds_out_if.source    result
);

  logic [4:0]  nd;
  logic [3:0]  nm;
  logic [15:0] ny;
  logic [3:0]  prev_m;

  assign prev_m = up.month - 4'd1;

  always_comb begin
    nd = up.day;
    nm = up.month;
    ny = up.year;
    if (!up.bad) begin
      if (up.op == cds_pkg::OP_NEXT) begin
        if (up.day == up.len) begin
          nd = cds_pkg::DAY_FIRST;
          if (up.month == cds_pkg::MONTH_DEC) begin
            nm = cds_pkg::MONTH_JAN;
            ny = up.year + 16'd1;
          end else begin
            nm = up.month + 4'd1;
          end
        end else begin
          nd = up.day + 5'd1;
        end
      end else begin
        if (up.day == cds_pkg::DAY_FIRST) begin
          if (up.month == cds_pkg::MONTH_JAN) begin
            nd = cds_pkg::DAYS_LONG;
            nm = cds_pkg::MONTH_DEC;
            ny = up.year - 16'd1;
          end else begin
            nm = prev_m;
            nd = cds_pkg::month_days(prev_m, up.leap);
          end
        end else begin
          nd = up.day - 5'd1;
        end
      end
    end
  end

  assign up_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      result.new_day      <= nd;
      result.new_month    <= nm;
      result.new_year     <= ny;
      result.month_length <= up.len;
      result.bad_date     <= up.bad;
    end
  end

  // a good input always lands on a month in 1..12 and a day in 1..31
  a_good_date: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.bad_date |->
      (result.new_month >= cds_pkg::MONTH_JAN) && (result.new_month <= cds_pkg::MONTH_DEC) &&
      (result.new_day >= cds_pkg::DAY_FIRST) && (result.new_day <= cds_pkg::DAYS_LONG))
    else $error("stepped date out of range");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.month_length >= cds_pkg::DAYS_FEB) &&
                     (result.month_length <= cds_pkg::DAYS_LONG))
    else $error("month length out of range");

  // a loaded result stays put until taken; year, day and bad flag are checked
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.new_year) &&
                                      $stable(result.new_day) && $stable(result.bad_date))
    else $error("result changed while stalled");

  // a February with 29 days only in a leap year
  a_leap_len: assert property (@(posedge clk) disable iff (rst)
    up_valid && (up.len == cds_pkg::DAYS_FEB_LP) |-> up.leap && (up.year[1:0] == 2'b00))
    else $error("29-day month in a common year");

endmodule

>>> rtl/core/calendar_day_step_unit.sv
// channel   dir  handshake     payload
// request   in   valid/ready   operation, day, month, year
// result    out  valid/ready   new_day, new_month, new_year, month_length, bad_date
//
// Three register stages (divide-by-25 multiply, leap/length/validity decode,
// date step into the result register); one item per cycle while result is not stalled.
// rst is synchronous, active high, and clears the stage valid bits only.
// A stall on result holds every stage whose successor is full; bubbles are
// squeezed out, so nothing is lost or repeated.
module calendar_day_step_unit (
  input  logic      clk,
  input  logic      rst,
  cds_in_if.sink    request,
  cds_out_if.source result
);

  cds_pkg::s1_t s1;
  logic         s1_valid;
  logic         s1_ready;
  cds_pkg::s2_t s2;
  logic         s2_valid;
  logic         s2_ready;

  // stage 1: year / 25 estimate, needed for the century rules
  cds_div25 u_div25 (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .stage       (s1),
    .stage_valid (s1_valid),
    .stage_ready (s1_ready)
  );

  // stage 2: leap year, month length, bad date flag
  cds_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .up          (s1),
    .up_valid    (s1_valid),
    .up_ready    (s1_ready),
    .stage       (s2),
    .stage_valid (s2_valid),
    .stage_ready (s2_ready)
  );

  // stage 3: next or previous day, held in the result register
  cds_step u_step (
    .clk      (clk),
    .rst      (rst),
    .up       (s2),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .result   (result)
  );

endmodule

>>> sim/tb_calendar_day_step_unit.sv
`timescale 1ns / 1ps

module tb_calendar_day_step_unit;

  // Cycles without any handshake on either channel before the run is declared hung.
  // The longest legitimate quiet stretch is the receiver hold-off plus pipeline
  // fill, so this leaves a wide margin.
  localparam int STALL_LIMIT   = 1000;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 12;
  localparam int REPORT_LIMIT  = 100;

  // What one result item should carry.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [4:0]  len;
    logic        bad;
  } date_result_t;

  logic clk = 1'b0;
  logic rst;

  cds_in_if  request ();
  cds_out_if result ();

  calendar_day_step_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Date arithmetic, worked out independently of the RTL.
  // ---------------------------------------------------------------------------

  // Gregorian rule: every fourth year, but not centuries unless divisible by 400.
  function automatic logic is_leap(input logic [15:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Out-of-range months fall back to the February length, as the block reports it.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [15:0] y);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = cds_pkg::DAYS_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = cds_pkg::DAYS_SHORT;
      default: n = is_leap(y) ? cds_pkg::DAYS_FEB_LP : cds_pkg::DAYS_FEB;
    endcase
    return n;
  endfunction

  // Neighbouring date; a bad input date comes back unchanged with the flag set.
  function automatic date_result_t step_date(input cds_pkg::op_t op, input logic [4:0] d,
                                             input logic [3:0] m, input logic [15:0] y);
    date_result_t r;
    r.day   = d;
    r.month = m;
    r.year  = y;
    r.len   = month_len(m, y);
    r.bad   = (m < cds_pkg::MONTH_JAN) || (m > cds_pkg::MONTH_DEC) ||
              (d < cds_pkg::DAY_FIRST) || (d > r.len);
    if (!r.bad) begin
      if (op == cds_pkg::OP_NEXT) begin
        if (d == r.len) begin
          r.day = cds_pkg::DAY_FIRST;
          if (m == cds_pkg::MONTH_DEC) begin
            r.month = cds_pkg::MONTH_JAN;
            r.year  = y + 16'd1;      // 65535 wraps to 0
          end else begin
            r.month = m + 4'd1;
          end
        end else begin
          r.day = d + 5'd1;
        end
      end else begin
        if (d == cds_pkg::DAY_FIRST) begin
          if (m == cds_pkg::MONTH_JAN) begin
            r.day   = cds_pkg::DAYS_LONG;
            r.month = cds_pkg::MONTH_DEC;
            r.year  = y - 16'd1;      // 0 wraps to 65535
          end else begin
            r.month = m - 4'd1;
            r.day   = month_len(r.month, y);
          end
        end else begin
          r.day = d - 5'd1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected results and checking
  // ---------------------------------------------------------------------------

  date_result_t pending_dates[$];
  date_result_t want_date;
  date_result_t got_date;
  int           mismatch_count = 0;

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Requests are queued before results are popped, so even a block that answers
  // in the same cycle as the request would be checked correctly.
  always @(posedge clk) begin
    if (!rst) begin
      if (request.valid && request.ready)
        pending_dates.push_back(step_date(request.operation, request.day,
                                          request.month, request.year));
      if (result.valid && result.ready) begin
        got_date.day   = result.new_day;
        got_date.month = result.new_month;
        got_date.year  = result.new_year;
        got_date.len   = result.month_length;
        got_date.bad   = result.bad_date;
        if (pending_dates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: result item with nothing expected, actual %p", $time, got_date);
        end else begin
          want_date = pending_dates.pop_front();
          compare_field("new_day",      16'(want_date.day),   16'(got_date.day));
          compare_field("new_month",    16'(want_date.month), 16'(got_date.month));
          compare_field("new_year",     want_date.year,       got_date.year);
          compare_field("month_length", 16'(want_date.len),   16'(got_date.len));
          compare_field("bad_date",     16'(want_date.bad),   16'(got_date.bad));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hang detection: any handshake on either side counts as progress.
  // ---------------------------------------------------------------------------

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. Cycles through stall patterns of its own; a test bumps
  // hold_seq to request one long hold-off, which is counted here.
  // ---------------------------------------------------------------------------

  int hold_seq = 0;

  always @(negedge clk) begin
    static int hold_seen  = 0;
    static int hold_left  = 0;
    static int mode       = 0;
    static int mode_left  = 0;
    static int tick       = 0;
    tick++;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES - 1;
      result.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 4);
        mode_left = $urandom_range(16, 48);
      end
      mode_left--;
      case (mode)
        0: result.ready <= 1'b1;                              // no stalls at all
        1: result.ready <= ($urandom_range(0, 3) != 0);       // occasional stall
        2: result.ready <= tick[0];                           // toggles, ready on odd ticks
        3: result.ready <= 1'($urandom_range(0, 1));          // coin toss
        default: result.ready <= ((tick % 8) < 5);            // short stall runs
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request sender. Called and returns at a falling edge. Items go out in
  // bursts of random length; the gap before a burst may be zero, so some
  // stretches carry no idling. no_gaps keeps valid high back to back.
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  bit no_gaps    = 1'b0;

  task automatic send_date(input cds_pkg::op_t op, input logic [4:0] d, input logic [3:0] m,
                           input logic [15:0] y);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        request.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0)
      burst_left--;
    request.valid     <= 1'b1;
    request.operation <= op;
    request.day       <= d;
    request.month     <= m;
    request.year      <= y;
    do @(posedge clk); while (!(request.valid && request.ready));
    @(negedge clk);
  endtask

  // Year with a bias towards the awkward ones: range ends, centuries, leap years.
  function automatic logic [15:0] pick_year();
    logic [15:0] y;
    case ($urandom_range(0, 7))
      0:       y = 16'd0;
      1:       y = 16'hFFFF;
      2:       y = 16'($urandom_range(0, 655) * 100);
      3:       y = 16'($urandom_range(0, 163) * 400);
      4:       y = 16'($urandom_range(0, 16383) * 4);
      default: y = 16'($urandom());
    endcase
    return y;
  endfunction

  // A valid date, mostly on or next to a month boundary, with a random step.
  task automatic send_valid_date();
    logic [3:0]  m;
    logic [15:0] y;
    logic [4:0]  n;
    logic [4:0]  d;
    m = 4'($urandom_range(1, 12));
    y = pick_year();
    n = month_len(m, y);
    case ($urandom_range(0, 3))
      0:       d = cds_pkg::DAY_FIRST;
      1:       d = n;
      2:       d = n - 5'd1;
      default: d = 5'($urandom_range(1, n));
    endcase
    send_date(cds_pkg::op_t'($urandom_range(0, 1)), d, m, y);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Year wrap both ways, leap rules, bad months and days, field extremes.
  task automatic test_directed_dates();
    send_date(cds_pkg::OP_NEXT, 5'd31, 4'd12, 16'hFFFF);   // wraps to 1 Jan 0
    send_date(cds_pkg::OP_PREV, 5'd1,  4'd1,  16'd0);      // wraps to 31 Dec 65535
    send_date(cds_pkg::OP_NEXT, 5'd28, 4'd2,  16'd2023);
    send_date(cds_pkg::OP_NEXT, 5'd28, 4'd2,  16'd2024);
    send_date(cds_pkg::OP_NEXT, 5'd29, 4'd2,  16'd2024);
    send_date(cds_pkg::OP_NEXT, 5'd29, 4'd2,  16'd2023);   // no 29th in a common year
    send_date(cds_pkg::OP_NEXT, 5'd29, 4'd2,  16'd1900);   // century, not leap
    send_date(cds_pkg::OP_PREV, 5'd1,  4'd3,  16'd2000);   // divisible by 400, leap
    send_date(cds_pkg::OP_PREV, 5'd1,  4'd3,  16'd1900);
    send_date(cds_pkg::OP_NEXT, 5'd29, 4'd2,  16'd0);      // year 0 counts as leap
    send_date(cds_pkg::OP_PREV, 5'd0,  4'd0,  16'd0);      // all-zero date
    send_date(cds_pkg::OP_NEXT, 5'd31, 4'd13, 16'hFFFF);
    send_date(cds_pkg::OP_PREV, 5'd31, 4'd15, 16'hFFFF);   // every input bit set
    send_date(cds_pkg::OP_NEXT, 5'd0,  4'd5,  16'd1234);   // day zero
    send_date(cds_pkg::OP_PREV, 5'd31, 4'd4,  16'd2021);   // day past a 30-day month
    send_date(cds_pkg::OP_NEXT, 5'd30, 4'd4,  16'd2021);
    send_date(cds_pkg::OP_PREV, 5'd1,  4'd5,  16'd2021);
    send_date(cds_pkg::OP_NEXT, 5'd31, 4'd1,  16'd2021);
    send_date(cds_pkg::OP_PREV, 5'd15, 4'd6,  16'd100);
    send_date(cds_pkg::OP_PREV, 5'd1,  4'd1,  16'hFFFF);
    send_date(cds_pkg::OP_NEXT, 5'd31, 4'd12, 16'd0);
    send_date(cds_pkg::OP_PREV, 5'd1,  4'd3,  16'd2100);
    send_date(cds_pkg::OP_NEXT, 5'd1,  4'd8,  16'd400);
    send_date(cds_pkg::OP_PREV, 5'd31, 4'd15, 16'd0);
    send_date(cds_pkg::OP_NEXT, 5'd5,  4'd0,  16'd2024);   // bad month, leap-year length
  endtask

  // Mostly well-formed dates; about one in seven is raw noise over all fields.
  task automatic test_random_dates(input int count);
    repeat (count) begin
      if ($urandom_range(0, 6) == 0)
        send_date(cds_pkg::op_t'($urandom_range(0, 1)), 5'($urandom()), 4'($urandom()),
                  16'($urandom()));
      else
        send_valid_date();
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming back to
  // back, so the pipeline fills and the request side has to stall.
  task automatic test_result_backpressure(input int count);
    no_gaps = 1'b1;
    hold_seq++;
    repeat (count) send_valid_date();
    no_gaps = 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    request.valid     = 1'b0;
    request.operation = cds_pkg::OP_NEXT;
    request.day       = '0;
    request.month     = '0;
    request.year      = '0;
    result.ready      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_dates();
    test_random_dates(200);
    test_result_backpressure(75);
    test_random_dates(150);

    request.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
